// File: rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer's RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDSPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDSPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sdspi_pkg.sv
// Types, codes and constants of the SD SPI command and sector read sequencer.
package sdspi_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam logic [9:0] SECTOR_LAST = 10'(SECTOR_BYTES - 1);

    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_BYTE = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_R1_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BUSY       = 2'd2;

    localparam logic [1:0] CMD_PREFIX  = 2'b01;
    localparam logic [7:0] CMD17_BYTE  = 8'h51;
    localparam logic [7:0] CMD18_BYTE  = 8'h52;
    localparam logic [7:0] CMD12_BYTE  = 8'h4C;
    localparam logic [7:0] TOKEN_BYTE  = 8'hFE;
    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [3:0] STOP_POLL_READS = 4'd9;
    localparam logic [9:0] FRAME_LEN   = 10'd6;
    localparam logic [9:0] ARG_LAST    = 10'd4;

    localparam logic [3:0] R1_LIMIT_RESET    = 4'd10;
    localparam logic [3:0] REPLY_LIMIT_RESET = 4'd9;

    typedef enum logic [10:0] {
        PH_IDLE       = 11'b000_0000_0001,
        PH_CMD_SEND   = 11'b000_0000_0010,
        PH_REPLY_POLL = 11'b000_0000_0100,
        PH_R1_POLL    = 11'b000_0000_1000,
        PH_TOKEN_WAIT = 11'b000_0001_0000,
        PH_DATA       = 11'b000_0010_0000,
        PH_CRC_SKIP   = 11'b000_0100_0000,
        PH_STOP_SEND  = 11'b000_1000_0000,
        PH_STOP_SKIP  = 11'b001_0000_0000,
        PH_STOP_POLL  = 11'b010_0000_0000,
        PH_BUSY_WAIT  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic [7:0]  crc_byte;
        logic [31:0] sector_address;
        logic [15:0] sector_count;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       sector_end;
        logic [7:0] reply;
        logic       reply_valid;
        logic [1:0] status;
        logic       chip_select;
        logic       transfer_done;
    } result_t;

    typedef struct packed {
        logic [3:0] r1_poll_limit;
        logic [3:0] reply_poll_limit;
    } limits_t;

endpackage

// File: rtl/core/sdspi_engine.sv
// Sequencer state and the per-exchange next-state and result logic.
`include "assert_macros.svh"

module sdspi_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sdspi_pkg::item_t   item,
    input  sdspi_pkg::limits_t limits,
    output sdspi_pkg::result_t res
);

    sdspi_pkg::phase_t phase_reg, phase_next;
    logic [9:0]  byte_counter_reg, byte_counter_next;
    logic [3:0]  poll_counter_reg, poll_counter_next;
    logic [15:0] sectors_left_reg, sectors_left_next;
    logic [31:0] frame_shift_reg, frame_shift_next;
    logic [7:0]  frame_tail_reg, frame_tail_next;
    logic        multi_block_reg, multi_block_next;
    logic        read_mode_reg, read_mode_next;

    logic [3:0]  poll_inc;
    logic [15:0] sectors_dec;

    assign poll_inc    = poll_counter_reg + 4'd1;
    assign sectors_dec = (sectors_left_reg != 16'd0) ? sectors_left_reg - 16'd1
                                                     : sectors_left_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        byte_counter_next = byte_counter_reg;
        poll_counter_next = poll_counter_reg;
        sectors_left_next = sectors_left_reg;
        frame_shift_next  = frame_shift_reg;
        frame_tail_next   = frame_tail_reg;
        multi_block_next  = multi_block_reg;
        read_mode_next    = read_mode_reg;
        res               = '0;

        case (item.action)
            sdspi_pkg::ACT_CMD, sdspi_pkg::ACT_READ:
            begin
                if (phase_reg != sdspi_pkg::PH_IDLE)
                begin
                    res.status = sdspi_pkg::ST_BUSY;
                end
                else if (item.action == sdspi_pkg::ACT_CMD)
                begin
                    read_mode_next    = 1'b0;
                    frame_shift_next  = item.argument;
                    frame_tail_next   = item.crc_byte;
                    byte_counter_next = 10'd1;
                    res.tx_byte       = {sdspi_pkg::CMD_PREFIX, item.command_index};
                    res.tx_valid      = 1'b1;
                    phase_next        = sdspi_pkg::PH_CMD_SEND;
                end
                else
                begin
                    read_mode_next    = 1'b1;
                    multi_block_next  = (item.sector_count > 16'd1);
                    sectors_left_next = (item.sector_count == 16'd0) ? 16'd1
                                                                     : item.sector_count;
                    frame_shift_next  = item.sector_address;
                    frame_tail_next   = 8'h00;
                    byte_counter_next = 10'd1;
                    res.tx_byte       = (item.sector_count > 16'd1) ? sdspi_pkg::CMD18_BYTE
                                                                    : sdspi_pkg::CMD17_BYTE;
                    res.tx_valid      = 1'b1;
                    phase_next        = sdspi_pkg::PH_CMD_SEND;
                end
            end
            sdspi_pkg::ACT_BYTE:
            begin
                case (phase_reg)
                    sdspi_pkg::PH_CMD_SEND, sdspi_pkg::PH_STOP_SEND:
                    begin
                        res.tx_valid = 1'b1;
                        if (byte_counter_reg < sdspi_pkg::FRAME_LEN)
                        begin
                            if (byte_counter_reg <= sdspi_pkg::ARG_LAST)
                            begin
                                res.tx_byte      = frame_shift_reg[31:24];
                                frame_shift_next = {frame_shift_reg[23:0], 8'h00};
                            end
                            else
                            begin
                                res.tx_byte = frame_tail_reg;
                            end
                            byte_counter_next = byte_counter_reg + 10'd1;
                        end
                        else
                        begin
                            res.tx_byte       = sdspi_pkg::FILL_BYTE;
                            poll_counter_next = 4'd0;
                            if (phase_reg == sdspi_pkg::PH_STOP_SEND)
                                phase_next = sdspi_pkg::PH_STOP_SKIP;
                            else if (read_mode_reg)
                                phase_next = sdspi_pkg::PH_R1_POLL;
                            else
                                phase_next = sdspi_pkg::PH_REPLY_POLL;
                        end
                    end
                    sdspi_pkg::PH_REPLY_POLL:
                    begin
                        poll_counter_next = poll_inc;
                        if (item.rx_byte != sdspi_pkg::FILL_BYTE
                            || poll_inc >= limits.reply_poll_limit)
                        begin
                            res.reply         = item.rx_byte;
                            res.reply_valid   = 1'b1;
                            res.transfer_done = 1'b1;
                            phase_next        = sdspi_pkg::PH_IDLE;
                        end
                        else
                        begin
                            res.tx_byte  = sdspi_pkg::FILL_BYTE;
                            res.tx_valid = 1'b1;
                        end
                    end
                    sdspi_pkg::PH_R1_POLL:
                    begin
                        poll_counter_next = poll_inc;
                        res.tx_byte       = sdspi_pkg::FILL_BYTE;
                        res.tx_valid      = 1'b1;
                        if (item.rx_byte == 8'h00)
                        begin
                            phase_next = sdspi_pkg::PH_TOKEN_WAIT;
                        end
                        else if (poll_inc >= limits.r1_poll_limit)
                        begin
                            res.status = sdspi_pkg::ST_R1_TIMEOUT;
                            phase_next = sdspi_pkg::PH_TOKEN_WAIT;
                        end
                    end
                    sdspi_pkg::PH_TOKEN_WAIT:
                    begin
                        res.tx_byte  = sdspi_pkg::FILL_BYTE;
                        res.tx_valid = 1'b1;
                        if (item.rx_byte == sdspi_pkg::TOKEN_BYTE)
                        begin
                            byte_counter_next = 10'd0;
                            phase_next        = sdspi_pkg::PH_DATA;
                        end
                    end
                    sdspi_pkg::PH_DATA:
                    begin
                        res.tx_byte    = sdspi_pkg::FILL_BYTE;
                        res.tx_valid   = 1'b1;
                        res.data_byte  = item.rx_byte;
                        res.data_valid = 1'b1;
                        if (byte_counter_reg >= sdspi_pkg::SECTOR_LAST)
                        begin
                            res.sector_end    = 1'b1;
                            byte_counter_next = 10'd0;
                            phase_next        = sdspi_pkg::PH_CRC_SKIP;
                        end
                        else
                        begin
                            byte_counter_next = byte_counter_reg + 10'd1;
                        end
                    end
                    sdspi_pkg::PH_CRC_SKIP:
                    begin
                        if (byte_counter_reg == 10'd0)
                        begin
                            byte_counter_next = 10'd1;
                            res.tx_byte       = sdspi_pkg::FILL_BYTE;
                            res.tx_valid      = 1'b1;
                        end
                        else
                        begin
                            byte_counter_next = 10'd0;
                            sectors_left_next = sectors_dec;
                            if (sectors_dec != 16'd0)
                            begin
                                res.tx_byte  = sdspi_pkg::FILL_BYTE;
                                res.tx_valid = 1'b1;
                                phase_next   = sdspi_pkg::PH_TOKEN_WAIT;
                            end
                            else if (multi_block_reg)
                            begin
                                // Stop transmission frame: CMD12, zero argument, zero CRC.
                                frame_shift_next  = 32'd0;
                                frame_tail_next   = 8'h00;
                                byte_counter_next = 10'd1;
                                res.tx_byte       = sdspi_pkg::CMD12_BYTE;
                                res.tx_valid      = 1'b1;
                                phase_next        = sdspi_pkg::PH_STOP_SEND;
                            end
                            else
                            begin
                                res.transfer_done = 1'b1;
                                read_mode_next    = 1'b0;
                                phase_next        = sdspi_pkg::PH_IDLE;
                            end
                        end
                    end
                    sdspi_pkg::PH_STOP_SKIP:
                    begin
                        res.tx_byte       = sdspi_pkg::FILL_BYTE;
                        res.tx_valid      = 1'b1;
                        poll_counter_next = 4'd0;
                        phase_next        = sdspi_pkg::PH_STOP_POLL;
                    end
                    sdspi_pkg::PH_STOP_POLL:
                    begin
                        poll_counter_next = poll_inc;
                        res.tx_byte       = sdspi_pkg::FILL_BYTE;
                        res.tx_valid      = 1'b1;
                        if (item.rx_byte != sdspi_pkg::FILL_BYTE
                            || poll_inc >= sdspi_pkg::STOP_POLL_READS)
                            phase_next = sdspi_pkg::PH_BUSY_WAIT;
                    end
                    sdspi_pkg::PH_BUSY_WAIT:
                    begin
                        // The card holds the line low while busy.
                        if (item.rx_byte == sdspi_pkg::FILL_BYTE)
                        begin
                            res.transfer_done = 1'b1;
                            read_mode_next    = 1'b0;
                            multi_block_next  = 1'b0;
                            phase_next        = sdspi_pkg::PH_IDLE;
                        end
                        else
                        begin
                            res.tx_byte  = sdspi_pkg::FILL_BYTE;
                            res.tx_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res.chip_select = (phase_next != sdspi_pkg::PH_IDLE) && read_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= sdspi_pkg::PH_IDLE;
            byte_counter_reg <= 10'd0;
            poll_counter_reg <= 4'd0;
            sectors_left_reg <= 16'd0;
            frame_shift_reg  <= 32'd0;
            frame_tail_reg   <= 8'h00;
            multi_block_reg  <= 1'b0;
            read_mode_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            byte_counter_reg <= byte_counter_next;
            poll_counter_reg <= poll_counter_next;
            sectors_left_reg <= sectors_left_next;
            frame_shift_reg  <= frame_shift_next;
            frame_tail_reg   <= frame_tail_next;
            multi_block_reg  <= multi_block_next;
            read_mode_reg    <= read_mode_next;
        end
    end

    `SDSPI_ASSERT_SAME(a_data_only_in_data_phase, step && res.data_valid, phase_reg == sdspi_pkg::PH_DATA, "payload byte outside data phase")
    `SDSPI_ASSERT_SAME(a_idle_byte_quiet, step && item.action == sdspi_pkg::ACT_BYTE && phase_reg == sdspi_pkg::PH_IDLE, !res.tx_valid && !res.transfer_done, "byte while idle produced activity")
    `SDSPI_ASSERT_NEXT(a_state_holds_without_step, !step, $stable(phase_reg) && $stable(byte_counter_reg), "sequencer state moved without a transaction")

endmodule

// File: rtl/core/sd_spi_command_and_sector_read_unit.sv
// Top level of the SD SPI command and sector read sequencer with its configuration port.
// An accepted item is held in the input register; its result then moves into the result register.
// Throughput: one item per cycle unless stalled; the next-state logic of the sequencer is the only path between them.
// While a finished result waits under stall, the input register can still take one item.
// Reset (rst_n low, asynchronous) empties both registers, puts the sequencer in idle and
// restores the poll limits to 10 (R1 after a read command) and 9 (plain command reply).
`include "assert_macros.svh"

module sd_spi_command_and_sector_read_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  action,
    input  logic [5:0]  command_index,
    input  logic [31:0] argument,
    input  logic [7:0]  crc_byte,
    input  logic [31:0] sector_address,
    input  logic [15:0] sector_count,
    input  logic [7:0]  rx_byte,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic        sector_end,
    output logic [7:0]  reply,
    output logic        reply_valid,
    output logic [1:0]  status,
    output logic        chip_select,
    output logic        transfer_done
);

    sdspi_pkg::limits_t limits_reg;
    sdspi_pkg::item_t   item_reg;
    sdspi_pkg::result_t result_reg;
    sdspi_pkg::result_t step_result;
    logic               item_full_reg;
    logic               result_full_reg;
    logic               out_free;
    logic               advance;
    logic               accept;
    logic               cfg_write;

    // Configuration registers; the word index is taken from paddr[2].
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.r1_poll_limit    <= sdspi_pkg::R1_LIMIT_RESET;
            limits_reg.reply_poll_limit <= sdspi_pkg::REPLY_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
                limits_reg.reply_poll_limit <= pwdata[3:0];
            else
                limits_reg.r1_poll_limit <= pwdata[3:0];
        end
    end

    assign prdata = paddr[2] ? {28'd0, limits_reg.reply_poll_limit}
                             : {28'd0, limits_reg.r1_poll_limit};

    // Two-register flow: the sequencer steps when the held item moves into the result register.
    assign out_free   = !result_full_reg || !result_stall;
    assign advance    = item_full_reg && out_free;
    assign item_stall = item_full_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg   <= 1'b0;
            result_full_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                item_full_reg <= 1'b1;
            else if (advance)
                item_full_reg <= 1'b0;

            if (advance)
                result_full_reg <= 1'b1;
            else if (!result_stall)
                result_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action         <= action;
            item_reg.command_index  <= command_index;
            item_reg.argument       <= argument;
            item_reg.crc_byte       <= crc_byte;
            item_reg.sector_address <= sector_address;
            item_reg.sector_count   <= sector_count;
            item_reg.rx_byte        <= rx_byte;
        end
        if (advance)
            result_reg <= step_result;
    end

    sdspi_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .limits (limits_reg),
        .res    (step_result)
    );

    assign result_valid  = result_full_reg;
    assign tx_byte       = result_reg.tx_byte;
    assign tx_valid      = result_reg.tx_valid;
    assign data_byte     = result_reg.data_byte;
    assign data_valid    = result_reg.data_valid;
    assign sector_end    = result_reg.sector_end;
    assign reply         = result_reg.reply;
    assign reply_valid   = result_reg.reply_valid;
    assign status        = result_reg.status;
    assign chip_select   = result_reg.chip_select;
    assign transfer_done = result_reg.transfer_done;

    `SDSPI_ASSERT_NEXT(a_advance_fills_result, advance, result_full_reg, "stepped transaction did not reach the result register")
    `SDSPI_ASSERT_SAME(a_stall_only_when_both_full, item_stall, item_full_reg && result_full_reg, "input stalled with room in the pipeline")
    `SDSPI_ASSERT_NEXT(a_held_item_kept, item_full_reg && !advance, item_full_reg && $stable(item_reg), "held transaction lost or overwritten")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SD SPI command and sector read sequencer.
module testbench;

    localparam logic [1:0] ACT_NONE        = 2'd3;
    localparam logic [7:0] CMD_FLAG        = 8'h40;
    localparam logic [7:0] READ_ONE_CMD    = CMD_FLAG | 8'd17;
    localparam logic [7:0] READ_MANY_CMD   = CMD_FLAG | 8'd18;
    localparam logic [7:0] STOP_CMD        = CMD_FLAG | 8'd12;
    localparam logic [7:0] DATA_TOKEN      = 8'hFE;
    localparam logic [7:0] IDLE_BYTE       = 8'hFF;
    localparam logic [3:0] STOP_REPLY_READS = 4'd9;
    localparam logic [9:0] FRAME_BYTES     = 10'd6;
    localparam logic [2:0] R1_LIMIT_ADDR   = 3'd0;
    localparam logic [2:0] REPLY_LIMIT_ADDR = 3'd4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int PHASE_ITEMS    = 130;

    // Tracks the sequencer state and holds the results still owed by the block.
    class exchange_tracker;
        logic [3:0]  r1_limit;
        logic [3:0]  reply_limit;
        sdspi_pkg::phase_t phase;
        logic [9:0]  byte_cnt;
        logic [3:0]  poll_cnt;
        logic [15:0] sectors_left;
        logic [31:0] arg_shift;
        logic [7:0]  frame_head;
        logic [7:0]  frame_tail;
        logic        multi;
        logic        reading;
        sdspi_pkg::result_t owed_results[$];
        int errors, n_in, n_out, n_cmds, n_reads, n_sectors;
        int n_r1_timeouts, n_reply_timeouts, n_rejects;

        function new();
            r1_limit = 4'd10;
            reply_limit = 4'd9;
            phase = sdspi_pkg::PH_IDLE;
            byte_cnt = '0;
            poll_cnt = '0;
            sectors_left = '0;
            arg_shift = '0;
            frame_head = '0;
            frame_tail = '0;
            multi = 1'b0;
            reading = 1'b0;
            errors = 0;
            n_in = 0;
            n_out = 0;
            n_cmds = 0;
            n_reads = 0;
            n_sectors = 0;
            n_r1_timeouts = 0;
            n_reply_timeouts = 0;
            n_rejects = 0;
        endfunction

        function void set_limit(logic [2:0] addr, logic [3:0] value);
            if (addr == R1_LIMIT_ADDR)
                r1_limit = value;
            else if (addr == REPLY_LIMIT_ADDR)
                reply_limit = value;
        endfunction

        function logic [7:0] load_frame(logic [7:0] head, logic [31:0] arg, logic [7:0] tail);
            frame_head = head;
            arg_shift = arg;
            frame_tail = tail;
            byte_cnt = 10'd1;
            return frame_head;
        endfunction

        function logic [7:0] frame_byte();
            logic [7:0] b;
            if (byte_cnt <= 10'd4)
            begin
                b = arg_shift[31:24];
                arg_shift = arg_shift << 8;
            end
            else
            begin
                b = frame_tail;
            end
            byte_cnt = byte_cnt + 10'd1;
            return b;
        endfunction

        // Advances the sequencer by one byte exchange and returns what it answers.
        function sdspi_pkg::result_t next_exchange(sdspi_pkg::item_t it);
            sdspi_pkg::result_t r;
            logic [15:0] cnt;
            r = '0;
            if (it.action == sdspi_pkg::ACT_CMD || it.action == sdspi_pkg::ACT_READ)
            begin
                if (phase != sdspi_pkg::PH_IDLE)
                begin
                    r.status = sdspi_pkg::ST_BUSY;
                    n_rejects++;
                end
                else if (it.action == sdspi_pkg::ACT_CMD)
                begin
                    reading = 1'b0;
                    r.tx_byte = load_frame(CMD_FLAG | {2'b00, it.command_index},
                                           it.argument, it.crc_byte);
                    r.tx_valid = 1'b1;
                    phase = sdspi_pkg::PH_CMD_SEND;
                    n_cmds++;
                end
                else
                begin
                    cnt = (it.sector_count == 16'd0) ? 16'd1 : it.sector_count;
                    reading = 1'b1;
                    multi = (cnt > 16'd1);
                    sectors_left = cnt;
                    r.tx_byte = load_frame(multi ? READ_MANY_CMD : READ_ONE_CMD,
                                           it.sector_address, 8'h00);
                    r.tx_valid = 1'b1;
                    phase = sdspi_pkg::PH_CMD_SEND;
                    n_reads++;
                end
            end
            else if (it.action == sdspi_pkg::ACT_BYTE)
            begin
                case (phase)
                    sdspi_pkg::PH_CMD_SEND, sdspi_pkg::PH_STOP_SEND:
                    begin
                        r.tx_valid = 1'b1;
                        if (byte_cnt < FRAME_BYTES)
                        begin
                            r.tx_byte = frame_byte();
                        end
                        else
                        begin
                            r.tx_byte = IDLE_BYTE;
                            poll_cnt = '0;
                            if (phase == sdspi_pkg::PH_STOP_SEND)
                                phase = sdspi_pkg::PH_STOP_SKIP;
                            else
                                phase = reading ? sdspi_pkg::PH_R1_POLL
                                                : sdspi_pkg::PH_REPLY_POLL;
                        end
                    end
                    sdspi_pkg::PH_REPLY_POLL:
                    begin
                        poll_cnt = poll_cnt + 4'd1;
                        if (it.rx_byte != IDLE_BYTE || poll_cnt >= reply_limit)
                        begin
                            r.reply = it.rx_byte;
                            r.reply_valid = 1'b1;
                            r.transfer_done = 1'b1;
                            phase = sdspi_pkg::PH_IDLE;
                            if (it.rx_byte == IDLE_BYTE)
                                n_reply_timeouts++;
                        end
                        else
                        begin
                            r.tx_byte = IDLE_BYTE;
                            r.tx_valid = 1'b1;
                        end
                    end
                    sdspi_pkg::PH_R1_POLL:
                    begin
                        poll_cnt = poll_cnt + 4'd1;
                        r.tx_byte = IDLE_BYTE;
                        r.tx_valid = 1'b1;
                        if (it.rx_byte == 8'h00)
                        begin
                            phase = sdspi_pkg::PH_TOKEN_WAIT;
                        end
                        else if (poll_cnt >= r1_limit)
                        begin
                            r.status = sdspi_pkg::ST_R1_TIMEOUT;
                            phase = sdspi_pkg::PH_TOKEN_WAIT;
                            n_r1_timeouts++;
                        end
                    end
                    sdspi_pkg::PH_TOKEN_WAIT:
                    begin
                        r.tx_byte = IDLE_BYTE;
                        r.tx_valid = 1'b1;
                        if (it.rx_byte == DATA_TOKEN)
                        begin
                            byte_cnt = '0;
                            phase = sdspi_pkg::PH_DATA;
                        end
                    end
                    sdspi_pkg::PH_DATA:
                    begin
                        r.tx_byte = IDLE_BYTE;
                        r.tx_valid = 1'b1;
                        r.data_byte = it.rx_byte;
                        r.data_valid = 1'b1;
                        if (int'(byte_cnt) + 1 >= sdspi_pkg::SECTOR_BYTES)
                        begin
                            r.sector_end = 1'b1;
                            byte_cnt = '0;
                            phase = sdspi_pkg::PH_CRC_SKIP;
                            n_sectors++;
                        end
                        else
                        begin
                            byte_cnt = byte_cnt + 10'd1;
                        end
                    end
                    sdspi_pkg::PH_CRC_SKIP:
                    begin
                        if (byte_cnt == 10'd0)
                        begin
                            byte_cnt = 10'd1;
                            r.tx_byte = IDLE_BYTE;
                            r.tx_valid = 1'b1;
                        end
                        else
                        begin
                            byte_cnt = '0;
                            if (sectors_left != 16'd0)
                                sectors_left = sectors_left - 16'd1;
                            if (sectors_left != 16'd0)
                            begin
                                r.tx_byte = IDLE_BYTE;
                                r.tx_valid = 1'b1;
                                phase = sdspi_pkg::PH_TOKEN_WAIT;
                            end
                            else if (multi)
                            begin
                                r.tx_byte = load_frame(STOP_CMD, 32'd0, 8'h00);
                                r.tx_valid = 1'b1;
                                phase = sdspi_pkg::PH_STOP_SEND;
                            end
                            else
                            begin
                                r.transfer_done = 1'b1;
                                reading = 1'b0;
                                phase = sdspi_pkg::PH_IDLE;
                            end
                        end
                    end
                    sdspi_pkg::PH_STOP_SKIP:
                    begin
                        r.tx_byte = IDLE_BYTE;
                        r.tx_valid = 1'b1;
                        poll_cnt = '0;
                        phase = sdspi_pkg::PH_STOP_POLL;
                    end
                    sdspi_pkg::PH_STOP_POLL:
                    begin
                        poll_cnt = poll_cnt + 4'd1;
                        r.tx_byte = IDLE_BYTE;
                        r.tx_valid = 1'b1;
                        if (it.rx_byte != IDLE_BYTE || poll_cnt >= STOP_REPLY_READS)
                            phase = sdspi_pkg::PH_BUSY_WAIT;
                    end
                    sdspi_pkg::PH_BUSY_WAIT:
                    begin
                        if (it.rx_byte == IDLE_BYTE)
                        begin
                            r.transfer_done = 1'b1;
                            reading = 1'b0;
                            multi = 1'b0;
                            phase = sdspi_pkg::PH_IDLE;
                        end
                        else
                        begin
                            r.tx_byte = IDLE_BYTE;
                            r.tx_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.chip_select = (phase != sdspi_pkg::PH_IDLE) && reading;
            return r;
        endfunction

        function void note(sdspi_pkg::item_t it);
            owed_results.push_back(next_exchange(it));
            n_in++;
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("result %0d %s = %0h, want %0h", n_out, name, got, want));
        endtask

        task check(sdspi_pkg::result_t got);
            sdspi_pkg::result_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result with no transaction outstanding: %0h", got));
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("tx_byte", got.tx_byte, want.tx_byte);
                check_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
                check_field("data_byte", got.data_byte, want.data_byte);
                check_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
                check_field("sector_end", 8'(got.sector_end), 8'(want.sector_end));
                check_field("reply", got.reply, want.reply);
                check_field("reply_valid", 8'(got.reply_valid), 8'(want.reply_valid));
                check_field("status", 8'(got.status), 8'(want.status));
                check_field("chip_select", 8'(got.chip_select), 8'(want.chip_select));
                check_field("transfer_done", 8'(got.transfer_done), 8'(want.transfer_done));
            end
            n_out++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  action = '0;
    logic [5:0]  command_index = '0;
    logic [31:0] argument = '0;
    logic [7:0]  crc_byte = '0;
    logic [31:0] sector_address = '0;
    logic [15:0] sector_count = '0;
    logic [7:0]  rx_byte = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        sector_end;
    logic [7:0]  reply;
    logic        reply_valid;
    logic [1:0]  status;
    logic        chip_select;
    logic        transfer_done;

    exchange_tracker sb = new();

    bit     in_idle = 1'b1;
    bit     out_idle = 1'b1;
    int     stall_left = 0;
    int     quiet_cycles = 0;
    sdspi_pkg::phase_t card_phase = sdspi_pkg::PH_IDLE;
    int     card_reads = 0;
    int     card_patience = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sd_spi_command_and_sector_read_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .command_index  (command_index),
        .argument       (argument),
        .crc_byte       (crc_byte),
        .sector_address (sector_address),
        .sector_count   (sector_count),
        .rx_byte        (rx_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .tx_byte        (tx_byte),
        .tx_valid       (tx_valid),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .sector_end     (sector_end),
        .reply          (reply),
        .reply_valid    (reply_valid),
        .status         (status),
        .chip_select    (chip_select),
        .transfer_done  (transfer_done)
    );

    // Result side: check each transaction, then hold stall for a random stretch.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check({tx_byte, tx_valid, data_byte, data_valid, sector_end,
                      reply, reply_valid, status, chip_select, transfer_done});
            stall_left = out_idle ? $urandom_range(0, 5) : 0;
            if ($urandom_range(0, 39) == 0)
                out_idle = !out_idle;
            result_stall <= (stall_left != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            if (stall_left == 0)
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function sdspi_pkg::item_t random_item();
        sdspi_pkg::item_t it;
        it.action = sdspi_pkg::ACT_BYTE;
        it.command_index = 6'($urandom_range(0, 63));
        it.argument = $urandom;
        it.crc_byte = 8'($urandom_range(0, 255));
        it.sector_address = $urandom;
        it.sector_count = 16'($urandom_range(0, 65535));
        it.rx_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Starts or no-op items while busy, or stray bytes or no-op items while idle; neither should disturb the sequencer.
    function sdspi_pkg::item_t noise_item(bit idle);
        sdspi_pkg::item_t it;
        it = random_item();
        if (idle)
            it.action = $urandom_range(0, 1) ? sdspi_pkg::ACT_BYTE : ACT_NONE;
        else
            case ($urandom_range(0, 2))
                0: it.action = sdspi_pkg::ACT_CMD;
                1: it.action = sdspi_pkg::ACT_READ;
                default: it.action = ACT_NONE;
            endcase
        return it;
    endfunction

    // Card behavior: how long it keeps the host waiting is drawn anew on each phase entry.
    function logic [7:0] card_byte();
        logic [7:0] b;
        logic       early;
        if (sb.phase != card_phase)
        begin
            card_phase = sb.phase;
            card_reads = 0;
            case (card_phase)
                sdspi_pkg::PH_REPLY_POLL, sdspi_pkg::PH_R1_POLL:
                    card_patience = $urandom_range(0, 16);
                sdspi_pkg::PH_STOP_POLL:
                    card_patience = $urandom_range(0, 11);
                default:
                    card_patience = $urandom_range(0, 4);
            endcase
        end
        early = (card_reads < card_patience);
        case (card_phase)
            sdspi_pkg::PH_REPLY_POLL, sdspi_pkg::PH_STOP_POLL:
                b = early ? IDLE_BYTE : 8'($urandom_range(0, 255));
            sdspi_pkg::PH_R1_POLL:
                b = early ? 8'($urandom_range(1, 255)) : 8'h00;
            sdspi_pkg::PH_TOKEN_WAIT:
                b = !early ? DATA_TOKEN :
                    ($urandom_range(0, 1) ? IDLE_BYTE : 8'($urandom_range(0, 253)));
            sdspi_pkg::PH_BUSY_WAIT:
                b = early ? 8'($urandom_range(0, 254)) : IDLE_BYTE;
            default:
                b = 8'($urandom_range(0, 255));
        endcase
        card_reads++;
        return b;
    endfunction

    task automatic send_item(input sdspi_pkg::item_t it);
        int gap;
        gap = in_idle ? $urandom_range(0, 5) : 0;
        if ($urandom_range(0, 39) == 0)
            in_idle = !in_idle;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= it.action;
        command_index <= it.command_index;
        argument <= it.argument;
        crc_byte <= it.crc_byte;
        sector_address <= it.sector_address;
        sector_count <= it.sector_count;
        rx_byte <= it.rx_byte;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note(it);
    endtask

    task automatic byte_xfer(input logic [7:0] rx);
        sdspi_pkg::item_t it;
        it = random_item();
        it.rx_byte = rx;
        send_item(it);
    endtask

    task automatic finish_op();
        while (sb.phase != sdspi_pkg::PH_IDLE)
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(noise_item(1'b0));
            else
                byte_xfer(card_byte());
        end
    endtask

    task automatic run_command();
        sdspi_pkg::item_t it;
        it = random_item();
        it.action = sdspi_pkg::ACT_CMD;
        it.argument = pick_word();
        send_item(it);
        finish_op();
    endtask

    task automatic run_read(input logic [15:0] count);
        sdspi_pkg::item_t it;
        it = random_item();
        it.action = sdspi_pkg::ACT_READ;
        it.sector_count = count;
        it.sector_address = pick_word();
        send_item(it);
        finish_op();
    endtask

    // Lets the pipeline empty so that a register write finds the block idle.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes a poll limit, then reads it back in a back-to-back access.
    task automatic write_limit(input logic [2:0] addr, input logic [3:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_limit(addr, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[3:0] !== value)
            sb.report($sformatf("register %0d reads %0h, written %0h", addr, prdata, value));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        sdspi_pkg::item_t it;
        int         base;
        logic [3:0] r1_set;
        logic [3:0] reply_set;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray inputs while idle, two plain commands at the reset limits, a read start while busy.
        byte_xfer(IDLE_BYTE);
        it = random_item();
        it.action = ACT_NONE;
        send_item(it);

        it = random_item();
        it.action = sdspi_pkg::ACT_CMD;
        it.command_index = 6'd63;
        it.argument = 32'hFFFF_FFFF;
        it.crc_byte = 8'hFF;
        send_item(it);
        repeat (3) byte_xfer(8'h00);
        it = random_item();
        it.action = sdspi_pkg::ACT_READ;
        it.sector_count = 16'hFFFF;
        it.sector_address = 32'hFFFF_FFFF;
        send_item(it);
        repeat (3) byte_xfer(8'hFF);
        it = random_item();
        it.action = ACT_NONE;
        send_item(it);
        byte_xfer(IDLE_BYTE);
        byte_xfer(8'h00);

        it = random_item();
        it.action = sdspi_pkg::ACT_CMD;
        it.command_index = 6'd0;
        it.argument = 32'd0;
        it.crc_byte = 8'h00;
        send_item(it);
        repeat (6) byte_xfer(8'h00);
        byte_xfer(8'h01);
        drain();

        // Random phases, each under its own poll limits; the first opens with a sector read
        // whose zero count stands for one sector.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    r1_set = 4'd15;
                    reply_set = 4'd15;
                end
                1:
                begin
                    r1_set = 4'd1;
                    reply_set = 4'd1;
                end
                2:
                begin
                    r1_set = 4'd0;
                    reply_set = 4'd0;
                end
                default:
                begin
                    r1_set = 4'($urandom_range(1, 15));
                    reply_set = 4'($urandom_range(1, 15));
                end
            endcase
            write_limit(R1_LIMIT_ADDR, r1_set);
            write_limit(REPLY_LIMIT_ADDR, reply_set);
            base = sb.n_in;
            if (p == 0)
                run_read(16'd0);
            while (sb.n_in - base < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(noise_item(1'b1));
                run_command();
            end
            drain();
        end

        $display("Run covered %0d transactions in, %0d out: %0d commands, %0d reads, %0d sectors",
                 sb.n_in, sb.n_out, sb.n_cmds, sb.n_reads, sb.n_sectors);
        $display("R1 timeouts %0d, reply timeouts %0d, rejected starts %0d, mismatches %0d",
                 sb.n_r1_timeouts, sb.n_reply_timeouts, sb.n_rejects, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sdspi_pkg.sv
rtl/core/sdspi_engine.sv
rtl/core/sd_spi_command_and_sector_read_unit.sv
verif/testbench.sv
